### sv/sfha_pkg.sv
package sfha_pkg;

    localparam int HEAP_WORDS  = 16384;
    localparam int NUM_CLASSES = 20;
    localparam int CHUNK_BYTES = 4096;

    localparam int AW    = $clog2(HEAP_WORDS);
    localparam int CLSW  = $clog2(NUM_CLASSES);
    localparam int HBW   = 17;

    localparam logic [31:0] USABLE_BYTES =
        ((HEAP_WORDS * 4) < 65536) ? 32'(HEAP_WORDS * 4) : 32'd65536;
    localparam int WALK_LIMIT = ((HEAP_WORDS * 4) < 65536 ? HEAP_WORDS * 4 : 65536) / 16 + 4;
    localparam int WALKW      = $clog2(WALK_LIMIT + 1);

    localparam logic [31:0] SIZE_MASK  = 32'hFFFF_FFF8;
    localparam logic [31:0] INIT_GROW  =
        32'((((CHUNK_BYTES / 4) + 1) / 2) * 8);

    localparam logic [1:0] OP_INIT  = 2'd0;
    localparam logic [1:0] OP_ALLOC = 2'd1;
    localparam logic [1:0] OP_FREE  = 2'd2;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_NOMEM = 2'd1;
    localparam logic [1:0] ST_ZERO  = 2'd2;

    typedef struct packed {
        logic          we;
        logic [AW-1:0] idx;
        logic [31:0]   wdata;
    } mem_req_t;

    // Size class: floor(log2(size)), clamped to the last class.
    function automatic logic [CLSW-1:0] size_class(input logic [31:0] size);
        logic [CLSW-1:0] c;
        c = '0;
        for (int i = 1; i < NUM_CLASSES; i++) begin
            if ((size >> i) != 32'd0) begin
                c = CLSW'(i);
            end
        end
        return c;
    endfunction

endpackage

### sv/sfha_heap_ram.sv
module sfha_heap_ram
(
    input  logic                   clk,
    input  sfha_pkg::mem_req_t     req,
    output logic [31:0]            q
);

    logic [31:0] mem [sfha_pkg::HEAP_WORDS];

    always_ff @(posedge clk)
    begin
        if (req.we)
        begin
            mem[req.idx] <= req.wdata;
        end
        q <= mem[req.idx];
    end

endmodule

### sv/segregated_fit_heap_allocator.sv
// Segregated-fit heap allocator with boundary tags.
// The input channel (in_valid, in_stall) carries one item: an opcode with a
// request size or a block address. An item is taken at a clock edge where
// in_valid is high and in_stall is low. The output channel (out_valid,
// out_stall) carries one result item per input item: a status and a payload
// address. A small sequencer drives one single-port heap memory, one word
// access per cycle, so the work for an item depends on its data: a request
// refused at once or a free whose header does not show a live block ends
// early, and an item runs longer when free lists are long, since each list
// step reads the memory port. in_stall stays high from the cycle after an
// item is taken until its result is placed in the output register.
// The output register lets the block take the next item while a result
// still waits; if the receiver stalls and a second result is ready, the
// sequencer holds in its final state until the register frees up.
// Reset clears the sequencer, the free-list heads and the heap break, so
// the heap reads as not initialized; no memory clearing pass is needed.
module segregated_fit_heap_allocator
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [1:0]  opcode,
    input  logic [15:0] request_size,
    input  logic [15:0] block_address,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [1:0]  status,
    output logic [15:0] address
);

    localparam int SW = 6;
    localparam logic [SW-1:0] S_IDLE = 6'd0,  S_FIN = 6'd1,
        S_I0 = 6'd2,  S_I1 = 6'd3,  S_I2 = 6'd4,  S_I3 = 6'd5,
        S_G0 = 6'd6,  S_G1 = 6'd7,  S_G2 = 6'd8,  S_G3 = 6'd9,
        S_AH = 6'd10, S_A0 = 6'd11, S_A1 = 6'd12, S_A2 = 6'd13,
        S_C0 = 6'd14, S_C1 = 6'd15, S_C2 = 6'd16, S_C3 = 6'd17,
        S_C4 = 6'd18, S_C5 = 6'd19, S_C6 = 6'd20,
        S_F0 = 6'd21, S_F1 = 6'd22, S_F2 = 6'd23,
        S_M0 = 6'd24, S_M1 = 6'd25, S_M2 = 6'd26, S_M3 = 6'd27,
        S_MA1 = 6'd28, S_MA2 = 6'd29, S_MA3 = 6'd30,
        S_MB1 = 6'd31, S_MB2 = 6'd32, S_MB3 = 6'd33, S_MB4 = 6'd34,
        S_MB5 = 6'd35, S_MB6 = 6'd36, S_MEND = 6'd37,
        S_R0 = 6'd38, S_R1 = 6'd39, S_R2 = 6'd40, S_R3 = 6'd41, S_R4 = 6'd42,
        S_L0 = 6'd43, S_L1 = 6'd44, S_L2 = 6'd45, S_L3 = 6'd46, S_L4 = 6'd47,
        S_L5 = 6'd48, S_L6 = 6'd49, S_L7 = 6'd50, S_L8 = 6'd51;

    localparam logic [1:0] MR_GROW = 2'd0, MR_CARVE = 2'd1, MR_FREE = 2'd2;

    logic [SW-1:0]                  state_reg, state_next;
    logic [SW-1:0]                  lret_reg, lret_next;
    logic [1:0]                     mret_reg, mret_next;
    logic [1:0]                     op_reg, op_next;
    logic [sfha_pkg::HBW-1:0]       hb_reg, hb_next;
    logic [15:0]                    heads_reg [sfha_pkg::NUM_CLASSES];
    logic [15:0]                    heads_next [sfha_pkg::NUM_CLASSES];
    logic [sfha_pkg::CLSW-1:0]      cls_reg, cls_next;
    logic [sfha_pkg::WALKW-1:0]     n_reg, n_next;
    logic [31:0] asize_reg, asize_next, bp_reg, bp_next, gbytes_reg, gbytes_next;
    logic [31:0] walk_reg, walk_next, prev_reg, prev_next, csize_reg, csize_next;
    logic [31:0] mbp_reg, mbp_next, msize_reg, msize_next, nxt_reg, nxt_next;
    logic [31:0] prv_reg, prv_next, lbp_reg, lbp_next, lsize_reg, lsize_next;
    logic        pa_reg, pa_next, na_reg, na_next;
    logic [1:0]  stat_reg, stat_next;
    logic [15:0] res_reg, res_next;
    logic        ovalid_reg, ovalid_next;
    logic [1:0]  ostat_reg, ostat_next;
    logic [15:0] oaddr_reg, oaddr_next;
    logic        rdok_reg;

    logic [31:0]        acc_addr, acc_wd, ram_q, rdq, blk, asize_in, gb_alloc, ext;
    logic               acc_we, in_range;
    sfha_pkg::mem_req_t mreq;

    assign in_range    = (acc_addr >> 2) < 32'(sfha_pkg::HEAP_WORDS);
    assign mreq.we     = acc_we && in_range;
    assign mreq.idx    = acc_addr[sfha_pkg::AW+1:2];
    assign mreq.wdata  = acc_wd;
    assign rdq         = rdok_reg ? ram_q : 32'd0;
    assign blk         = rdq & sfha_pkg::SIZE_MASK;

    // Block size for a request, and heap growth for an allocate that misses.
    assign asize_in = (request_size <= 16'd8) ? 32'd16
                    : ((32'(request_size) + 32'd15) & sfha_pkg::SIZE_MASK);
    assign ext      = (asize_reg > 32'(sfha_pkg::CHUNK_BYTES)) ? asize_reg
                    : 32'(sfha_pkg::CHUNK_BYTES);
    assign gb_alloc = (((ext >> 2) + 32'd1) & 32'hFFFF_FFFE) << 2;

    sfha_heap_ram u_ram
    (
        .clk (clk),
        .req (mreq),
        .q   (ram_q)
    );

    assign in_stall  = (state_reg != S_IDLE);
    assign out_valid = ovalid_reg;
    assign status    = ostat_reg;
    assign address   = oaddr_reg;

    always_comb
    begin
        state_next  = state_reg;   lret_next  = lret_reg;   mret_next = mret_reg;
        op_next     = op_reg;      hb_next    = hb_reg;     heads_next = heads_reg;
        cls_next    = cls_reg;     n_next     = n_reg;      asize_next = asize_reg;
        bp_next     = bp_reg;      gbytes_next = gbytes_reg; walk_next = walk_reg;
        prev_next   = prev_reg;    csize_next = csize_reg;  mbp_next  = mbp_reg;
        msize_next  = msize_reg;   nxt_next   = nxt_reg;    prv_next  = prv_reg;
        lbp_next    = lbp_reg;     lsize_next = lsize_reg;  pa_next   = pa_reg;
        na_next     = na_reg;      stat_next  = stat_reg;   res_next  = res_reg;
        ovalid_next = ovalid_reg;  ostat_next = ostat_reg;  oaddr_next = oaddr_reg;
        acc_addr    = 32'd0;
        acc_wd      = 32'd0;
        acc_we      = 1'b0;

        if (ovalid_reg && !out_stall)
        begin
            ovalid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    op_next    = opcode;
                    stat_next  = sfha_pkg::ST_OK;
                    res_next   = 16'd0;
                    state_next = S_FIN;
                    priority if (opcode == sfha_pkg::OP_INIT)
                    begin
                        state_next = S_I0;
                    end
                    else if (opcode == sfha_pkg::OP_ALLOC)
                    begin
                        if (request_size == 16'd0)
                        begin
                            stat_next = sfha_pkg::ST_ZERO;
                        end
                        else if (hb_reg == '0)
                        begin
                            stat_next = sfha_pkg::ST_NOMEM;
                        end
                        else
                        begin
                            asize_next = asize_in;
                            cls_next   = sfha_pkg::size_class(asize_in);
                            state_next = S_AH;
                        end
                    end
                    else if (opcode == sfha_pkg::OP_FREE)
                    begin
                        if (hb_reg != '0 && block_address[2:0] == 3'd0
                            && block_address >= 16'd16
                            && 17'(block_address) < hb_reg)
                        begin
                            state_next = S_F0;
                        end
                    end
                    else
                    begin
                        state_next = S_FIN;
                    end
                    bp_next = 32'(block_address);
                end
            end
            S_FIN:
            begin
                if (!ovalid_reg || !out_stall)
                begin
                    ovalid_next = 1'b1;
                    ostat_next  = stat_reg;
                    oaddr_next  = res_reg;
                    state_next  = S_IDLE;
                end
            end
            // Init: pad, prologue, epilogue, then grow by one chunk.
            S_I0:
            begin
                acc_we  = 1'b1;
                hb_next = 17'd16;
                for (int i = 0; i < sfha_pkg::NUM_CLASSES; i++)
                begin
                    heads_next[i] = 16'd0;
                end
                state_next = S_I1;
            end
            S_I1:
            begin
                acc_addr = 32'd4;  acc_wd = 32'd9;  acc_we = 1'b1;
                state_next = S_I2;
            end
            S_I2:
            begin
                acc_addr = 32'd8;  acc_wd = 32'd9;  acc_we = 1'b1;
                state_next = S_I3;
            end
            S_I3:
            begin
                acc_addr = 32'd12; acc_wd = 32'd1;  acc_we = 1'b1;
                gbytes_next = sfha_pkg::INIT_GROW;
                state_next  = S_G0;
            end
            // Grow the heap by gbytes and merge the new block.
            S_G0:
            begin
                if (gbytes_reg > sfha_pkg::USABLE_BYTES
                    || 32'(hb_reg) > sfha_pkg::USABLE_BYTES - gbytes_reg)
                begin
                    stat_next  = sfha_pkg::ST_NOMEM;
                    res_next   = 16'd0;
                    state_next = S_FIN;
                end
                else
                begin
                    bp_next    = 32'(hb_reg);
                    hb_next    = sfha_pkg::HBW'(32'(hb_reg) + gbytes_reg);
                    state_next = S_G1;
                end
            end
            S_G1:
            begin
                acc_addr = bp_reg - 32'd4; acc_wd = gbytes_reg; acc_we = 1'b1;
                state_next = S_G2;
            end
            S_G2:
            begin
                acc_addr = bp_reg + gbytes_reg - 32'd8; acc_wd = gbytes_reg; acc_we = 1'b1;
                state_next = S_G3;
            end
            S_G3:
            begin
                acc_addr = bp_reg + gbytes_reg - 32'd4; acc_wd = 32'd1; acc_we = 1'b1;
                mbp_next   = bp_reg;
                mret_next  = MR_GROW;
                state_next = S_M0;
            end
            // First fit over the size classes.
            S_AH:
            begin
                walk_next  = 32'(heads_reg[cls_reg]);
                n_next     = '0;
                state_next = S_A0;
            end
            S_A0:
            begin
                acc_addr = walk_reg - 32'd4;
                if (walk_reg != 32'd0)
                begin
                    state_next = S_A1;
                end
                else if (cls_reg == sfha_pkg::CLSW'(sfha_pkg::NUM_CLASSES - 1))
                begin
                    gbytes_next = gb_alloc;
                    state_next  = S_G0;
                end
                else
                begin
                    cls_next   = cls_reg + 1'b1;
                    state_next = S_AH;
                end
            end
            S_A1:
            begin
                acc_addr = walk_reg + 32'd4;
                if (asize_reg <= blk)
                begin
                    bp_next    = walk_reg;
                    state_next = S_C0;
                end
                else if (32'(n_reg) < 32'(sfha_pkg::WALK_LIMIT))
                begin
                    state_next = S_A2;
                end
                else if (cls_reg == sfha_pkg::CLSW'(sfha_pkg::NUM_CLASSES - 1))
                begin
                    gbytes_next = gb_alloc;
                    state_next  = S_G0;
                end
                else
                begin
                    cls_next   = cls_reg + 1'b1;
                    state_next = S_AH;
                end
            end
            S_A2:
            begin
                walk_next  = rdq;
                n_next     = n_reg + 1'b1;
                state_next = S_A0;
            end
            // Carve the allocated block out of a free one.
            S_C0:
            begin
                acc_addr   = bp_reg - 32'd4;
                state_next = S_C1;
            end
            S_C1:
            begin
                csize_next = blk;
                lbp_next   = bp_reg;
                lret_next  = S_C2;
                state_next = S_R0;
            end
            S_C2:
            begin
                acc_addr = bp_reg - 32'd4;
                acc_we   = 1'b1;
                if (csize_reg >= asize_reg && csize_reg - asize_reg >= 32'd16)
                begin
                    acc_wd     = asize_reg | 32'd1;
                    state_next = S_C3;
                end
                else
                begin
                    acc_wd     = csize_reg | 32'd1;
                    state_next = S_C6;
                end
            end
            S_C3:
            begin
                acc_addr = bp_reg + asize_reg - 32'd8; acc_wd = asize_reg | 32'd1;
                acc_we   = 1'b1;
                state_next = S_C4;
            end
            S_C4:
            begin
                acc_addr = bp_reg + asize_reg - 32'd4; acc_wd = csize_reg - asize_reg;
                acc_we   = 1'b1;
                state_next = S_C5;
            end
            S_C5:
            begin
                acc_addr = bp_reg + csize_reg - 32'd8; acc_wd = csize_reg - asize_reg;
                acc_we   = 1'b1;
                mbp_next   = bp_reg + asize_reg;
                mret_next  = MR_CARVE;
                state_next = S_M0;
            end
            S_C6:
            begin
                acc_addr = bp_reg + csize_reg - 32'd8; acc_wd = csize_reg | 32'd1;
                acc_we   = 1'b1;
                stat_next  = sfha_pkg::ST_OK;
                res_next   = bp_reg[15:0];
                state_next = S_FIN;
            end
            // Free: check the header, clear the allocated bits, merge.
            S_F0:
            begin
                acc_addr   = bp_reg - 32'd4;
                state_next = S_F1;
            end
            S_F1:
            begin
                acc_addr   = bp_reg - 32'd4;
                acc_wd     = blk;
                csize_next = blk;
                if (rdq[0] && blk >= 32'd16 && blk <= 32'(hb_reg) - bp_reg)
                begin
                    acc_we     = 1'b1;
                    state_next = S_F2;
                end
                else
                begin
                    state_next = S_FIN;
                end
            end
            S_F2:
            begin
                acc_addr = bp_reg + csize_reg - 32'd8; acc_wd = csize_reg; acc_we = 1'b1;
                mbp_next   = bp_reg;
                mret_next  = MR_FREE;
                state_next = S_M0;
            end
            // Coalesce the free block at mbp with its neighbors.
            S_M0:
            begin
                acc_addr   = mbp_reg - 32'd4;
                state_next = S_M1;
            end
            S_M1:
            begin
                msize_next = blk;
                acc_addr   = mbp_reg - 32'd8;
                state_next = S_M2;
            end
            S_M2:
            begin
                pa_next    = rdq[0];
                prv_next   = mbp_reg - blk;
                nxt_next   = mbp_reg + msize_reg;
                acc_addr   = mbp_reg + msize_reg - 32'd4;
                state_next = S_M3;
            end
            S_M3:
            begin
                na_next = rdq[0];
                if (pa_reg && rdq[0])
                begin
                    lbp_next   = mbp_reg;
                    lsize_next = msize_reg;
                    lret_next  = S_MEND;
                    state_next = S_L0;
                end
                else if (pa_reg)
                begin
                    lbp_next   = nxt_reg;
                    lret_next  = S_MA1;
                    state_next = S_R0;
                end
                else
                begin
                    lbp_next   = prv_reg;
                    lret_next  = S_MB1;
                    state_next = S_R0;
                end
            end
            S_MA1:
            begin
                acc_addr   = nxt_reg - 32'd4;
                state_next = S_MA2;
            end
            S_MA2:
            begin
                msize_next = msize_reg + blk;
                acc_addr   = mbp_reg - 32'd4;
                acc_wd     = msize_reg + blk;
                acc_we     = 1'b1;
                state_next = S_MA3;
            end
            S_MA3:
            begin
                acc_addr = mbp_reg + msize_reg - 32'd8; acc_wd = msize_reg; acc_we = 1'b1;
                lbp_next   = mbp_reg;
                lsize_next = msize_reg;
                lret_next  = S_MEND;
                state_next = S_L0;
            end
            S_MB1:
            begin
                if (!na_reg)
                begin
                    lbp_next   = nxt_reg;
                    lret_next  = S_MB2;
                    state_next = S_R0;
                end
                else
                begin
                    state_next = S_MB4;
                end
            end
            S_MB2:
            begin
                acc_addr   = nxt_reg - 32'd4;
                state_next = S_MB3;
            end
            S_MB3:
            begin
                msize_next = msize_reg + blk;
                state_next = S_MB4;
            end
            S_MB4:
            begin
                acc_addr   = prv_reg - 32'd4;
                state_next = S_MB5;
            end
            S_MB5:
            begin
                msize_next = msize_reg + blk;
                acc_addr   = prv_reg - 32'd4;
                acc_wd     = msize_reg + blk;
                acc_we     = 1'b1;
                state_next = S_MB6;
            end
            S_MB6:
            begin
                acc_addr = prv_reg + msize_reg - 32'd8; acc_wd = msize_reg; acc_we = 1'b1;
                mbp_next   = prv_reg;
                lbp_next   = prv_reg;
                lsize_next = msize_reg;
                lret_next  = S_MEND;
                state_next = S_L0;
            end
            S_MEND:
            begin
                stat_next  = sfha_pkg::ST_OK;
                state_next = S_FIN;
                unique case (mret_reg)
                    MR_GROW:
                    begin
                        bp_next = mbp_reg;
                        if (op_reg == sfha_pkg::OP_ALLOC)
                        begin
                            state_next = S_C0;
                        end
                    end
                    MR_CARVE:
                    begin
                        res_next = bp_reg[15:0];
                    end
                    default:
                    begin
                        res_next = 16'd0;
                    end
                endcase
            end
            // Unlink the free block at lbp.
            S_R0:
            begin
                acc_addr   = lbp_reg - 32'd4;
                state_next = S_R1;
            end
            S_R1:
            begin
                cls_next   = sfha_pkg::size_class(blk);
                acc_addr   = lbp_reg;
                state_next = S_R2;
            end
            S_R2:
            begin
                prev_next  = rdq;
                acc_addr   = lbp_reg + 32'd4;
                state_next = S_R3;
            end
            S_R3:
            begin
                walk_next  = rdq;
                acc_addr   = rdq;
                acc_wd     = prev_reg;
                acc_we     = (rdq != 32'd0);
                state_next = S_R4;
            end
            S_R4:
            begin
                acc_addr = prev_reg + 32'd4;
                acc_wd   = walk_reg;
                if (prev_reg != 32'd0)
                begin
                    acc_we = 1'b1;
                end
                else
                begin
                    heads_next[cls_reg] = walk_reg[15:0];
                end
                state_next = lret_reg;
            end
            // Insert lbp of size lsize into its class list, ascending size.
            S_L0:
            begin
                cls_next   = sfha_pkg::size_class(lsize_reg);
                state_next = S_L1;
            end
            S_L1:
            begin
                walk_next  = 32'(heads_reg[cls_reg]);
                prev_next  = 32'd0;
                n_next     = '0;
                state_next = S_L2;
            end
            S_L2:
            begin
                acc_addr = walk_reg - 32'd4;
                if (walk_reg != 32'd0 && 32'(n_reg) < 32'(sfha_pkg::WALK_LIMIT))
                begin
                    state_next = S_L3;
                end
                else
                begin
                    state_next = S_L5;
                end
            end
            S_L3:
            begin
                acc_addr = walk_reg + 32'd4;
                if (lsize_reg > blk)
                begin
                    prev_next  = walk_reg;
                    state_next = S_L4;
                end
                else
                begin
                    state_next = S_L5;
                end
            end
            S_L4:
            begin
                walk_next  = rdq;
                n_next     = n_reg + 1'b1;
                state_next = S_L2;
            end
            S_L5:
            begin
                acc_addr = lbp_reg + 32'd4; acc_wd = walk_reg; acc_we = 1'b1;
                state_next = S_L6;
            end
            S_L6:
            begin
                acc_addr = lbp_reg; acc_wd = prev_reg; acc_we = 1'b1;
                state_next = S_L7;
            end
            S_L7:
            begin
                acc_addr = walk_reg; acc_wd = lbp_reg; acc_we = (walk_reg != 32'd0);
                state_next = S_L8;
            end
            S_L8:
            begin
                acc_addr = prev_reg + 32'd4;
                acc_wd   = lbp_reg;
                if (prev_reg != 32'd0)
                begin
                    acc_we = 1'b1;
                end
                else
                begin
                    heads_next[cls_reg] = lbp_reg[15:0];
                end
                state_next = lret_reg;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            lret_reg   <= S_IDLE;
            mret_reg   <= MR_GROW;
            hb_reg     <= '0;
            ovalid_reg <= 1'b0;
            cls_reg    <= '0;
            for (int i = 0; i < sfha_pkg::NUM_CLASSES; i++)
            begin
                heads_reg[i] <= 16'd0;
            end
        end
        else
        begin
            state_reg  <= state_next;
            lret_reg   <= lret_next;
            mret_reg   <= mret_next;
            hb_reg     <= hb_next;
            ovalid_reg <= ovalid_next;
            cls_reg    <= cls_next;
            heads_reg  <= heads_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg     <= op_next;     n_reg      <= n_next;      asize_reg <= asize_next;
        bp_reg     <= bp_next;     gbytes_reg <= gbytes_next; walk_reg  <= walk_next;
        prev_reg   <= prev_next;   csize_reg  <= csize_next;  mbp_reg   <= mbp_next;
        msize_reg  <= msize_next;  nxt_reg    <= nxt_next;    prv_reg   <= prv_next;
        lbp_reg    <= lbp_next;    lsize_reg  <= lsize_next;  pa_reg    <= pa_next;
        na_reg     <= na_next;     stat_reg   <= stat_next;   res_reg   <= res_next;
        ostat_reg  <= ostat_next;  oaddr_reg  <= oaddr_next;
        rdok_reg   <= in_range;
    end

    // A result only appears from the final state of the sequencer.
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(ovalid_reg) |-> $past(state_reg == S_FIN))
        else $error("result appeared outside the final state");

    // The heap break never passes the usable heap.
    assert property (@(posedge clk) disable iff (!rst_n)
        32'(hb_reg) <= sfha_pkg::USABLE_BYTES)
        else $error("heap break past usable heap");

    // The class index always names a real list.
    assert property (@(posedge clk) disable iff (!rst_n)
        32'(cls_reg) < 32'(sfha_pkg::NUM_CLASSES))
        else $error("class index out of range");

    // An accepted item stalls the input: the sequencer has left idle once the item is taken.
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> (in_stall && state_reg != S_IDLE))
        else $error("input not stalled after accept");

endmodule

### test/tb_segregated_fit_heap_allocator.sv
module tb_segregated_fit_heap_allocator;
    timeunit 1ns;
    timeprecision 1ps;

    // Opcode 3 is a no-operation item that still returns one result.
    localparam logic [1:0] OP_NOP = 2'd3;

    // The watchdog trips after this many cycles with no item moving on either side.
    localparam int IDLE_LIMIT = 100000;
    localparam int RANDOM_ITEMS = 1300;

    // The receiver holds off for a long stretch starting at this cycle.
    localparam int HOLD_START  = 4000;
    localparam int HOLD_CYCLES = 300;

    typedef struct {
        logic [1:0]  st;
        logic [15:0] ad;
    } reply_t;

    typedef struct {
        logic [1:0]  op;
        logic [15:0] req;
        logic [15:0] addr;
        reply_t      reply;
    } heap_op_t;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_stall;
    logic [1:0]  opcode;
    logic [15:0] request_size;
    logic [15:0] block_address;
    logic        out_valid;
    logic        out_stall;
    logic [1:0]  status;
    logic [15:0] address;

    segregated_fit_heap_allocator u_top
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .opcode        (opcode),
        .request_size  (request_size),
        .block_address (block_address),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .status        (status),
        .address       (address)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #6 clk = ~clk;

    // ------------------------------------------------------------------
    // Shadow heap. These mirror the block's memory, free-list heads and
    // heap break, and are advanced as each item is generated. Items reach
    // the block in the same order, so the prediction made here is the one
    // the block must produce when the item is accepted.
    // ------------------------------------------------------------------
    bit [31:0] shadow_mem [sfha_pkg::HEAP_WORDS];
    bit [31:0] shadow_heads [sfha_pkg::NUM_CLASSES];
    bit [31:0] shadow_break;

    // Payload offsets of blocks that are currently allocated, and of
    // blocks that have been released at some point.
    bit [15:0] live_blocks [$];
    bit [15:0] released_blocks [$];

    heap_op_t  pending_ops [$];
    reply_t    awaited_replies [$];
    int        error_count;

    function automatic bit [31:0] mem_read(bit [31:0] a);
        bit [31:0] w;
        w = a >> 2;
        return (w < sfha_pkg::HEAP_WORDS) ? shadow_mem[w] : 32'd0;
    endfunction

    function automatic void mem_write(bit [31:0] a, bit [31:0] v);
        bit [31:0] w;
        w = a >> 2;
        if (w < sfha_pkg::HEAP_WORDS)
        begin
            shadow_mem[w] = v;
        end
    endfunction

    function automatic bit [31:0] block_bytes(bit [31:0] bp);
        return mem_read(bp - 32'd4) & sfha_pkg::SIZE_MASK;
    endfunction

    function automatic int bin_of(bit [31:0] size);
        int i;
        i = 0;
        while (i < sfha_pkg::NUM_CLASSES - 1 && size > 32'd1)
        begin
            size = size >> 1;
            i++;
        end
        return i;
    endfunction

    function automatic void unlink_free(bit [31:0] bp);
        int        c;
        bit [31:0] p;
        bit [31:0] s;
        c = bin_of(block_bytes(bp));
        p = mem_read(bp);
        s = mem_read(bp + 32'd4);
        if (s != 0)
        begin
            mem_write(s, p);
        end
        if (p != 0)
        begin
            mem_write(p + 32'd4, s);
        end
        else
        begin
            shadow_heads[c] = s & 32'hFFFF;
        end
    endfunction

    // Free lists are kept sorted by ascending full block size.
    function automatic void link_sorted(bit [31:0] bp, bit [31:0] size);
        int        c;
        bit [31:0] prv;
        bit [31:0] nxt;
        int        n;
        c = bin_of(size);
        prv = 0;
        nxt = shadow_heads[c];
        n = 0;
        while (nxt != 0 && size > block_bytes(nxt) && n < sfha_pkg::WALK_LIMIT)
        begin
            prv = nxt;
            nxt = mem_read(nxt + 32'd4);
            n++;
        end
        mem_write(bp + 32'd4, nxt);
        mem_write(bp, prv);
        if (nxt != 0)
        begin
            mem_write(nxt, bp);
        end
        if (prv != 0)
        begin
            mem_write(prv + 32'd4, bp);
        end
        else
        begin
            shadow_heads[c] = bp & 32'hFFFF;
        end
    endfunction

    function automatic bit [31:0] coalesce(bit [31:0] bp);
        bit [31:0] size;
        bit        prev_used;
        bit        next_used;
        bit [31:0] nxt;
        bit [31:0] prv;
        size = block_bytes(bp);
        prev_used = 1'(mem_read(bp - 32'd8) & 32'd1);
        nxt = bp + size;
        next_used = 1'(mem_read(nxt - 32'd4) & 32'd1);
        if (prev_used && next_used)
        begin
            link_sorted(bp, size);
            return bp;
        end
        if (prev_used)
        begin
            unlink_free(nxt);
            size += block_bytes(nxt);
            mem_write(bp - 32'd4, size);
            mem_write(bp + size - 32'd8, size);
        end
        else
        begin
            prv = bp - (mem_read(bp - 32'd8) & sfha_pkg::SIZE_MASK);
            unlink_free(prv);
            if (!next_used)
            begin
                unlink_free(nxt);
                size += block_bytes(nxt);
            end
            size += block_bytes(prv);
            mem_write(prv - 32'd4, size);
            mem_write(prv + size - 32'd8, size);
            bp = prv;
        end
        link_sorted(bp, size);
        return bp;
    endfunction

    function automatic bit [31:0] grow_shadow_heap(bit [31:0] words);
        bit [31:0] bytes;
        bit [31:0] bp;
        bytes = ((words + 32'd1) & ~32'd1) * 32'd4;
        bp = shadow_break;
        if (bytes > sfha_pkg::USABLE_BYTES || bp > sfha_pkg::USABLE_BYTES - bytes)
        begin
            return 0;
        end
        shadow_break = bp + bytes;
        mem_write(bp - 32'd4, bytes);
        mem_write(bp + bytes - 32'd8, bytes);
        mem_write(bp + bytes - 32'd4, 32'd1);
        return coalesce(bp);
    endfunction

    function automatic bit [31:0] search_lists(bit [31:0] asize);
        bit [31:0] bp;
        int        n;
        for (int i = 0; i < sfha_pkg::NUM_CLASSES; i++)
        begin
            if (i == sfha_pkg::NUM_CLASSES - 1 || (asize >> i) <= 32'd1)
            begin
                bp = shadow_heads[i];
                n = 0;
                while (bp != 0 && asize > block_bytes(bp) && n < sfha_pkg::WALK_LIMIT)
                begin
                    bp = mem_read(bp + 32'd4);
                    n++;
                end
                if (bp != 0 && asize <= block_bytes(bp))
                begin
                    return bp;
                end
            end
        end
        return 0;
    endfunction

    // Take asize bytes from the front of a free block; a leftover of at
    // least 16 bytes goes back on the lists as a block of its own.
    function automatic void place_block(bit [31:0] bp, bit [31:0] asize);
        bit [31:0] csize;
        bit [31:0] rest;
        bit [31:0] dummy;
        csize = block_bytes(bp);
        unlink_free(bp);
        if (csize >= asize && csize - asize >= 32'd16)
        begin
            rest = bp + asize;
            mem_write(bp - 32'd4, asize | 32'd1);
            mem_write(bp + asize - 32'd8, asize | 32'd1);
            mem_write(rest - 32'd4, csize - asize);
            mem_write(rest + (csize - asize) - 32'd8, csize - asize);
            dummy = coalesce(rest);
        end
        else
        begin
            mem_write(bp - 32'd4, csize | 32'd1);
            mem_write(bp + csize - 32'd8, csize | 32'd1);
        end
    endfunction

    function automatic reply_t heap_step(logic [1:0] op, logic [15:0] req, logic [15:0] addr);
        reply_t    r;
        bit [31:0] asize;
        bit [31:0] bp;
        bit [31:0] ext;
        bit [31:0] hdr;
        bit [31:0] size;
        r.st = sfha_pkg::ST_OK;
        r.ad = '0;
        unique case (op)
            sfha_pkg::OP_INIT:
            begin
                shadow_break = 16;
                mem_write(0, 0);
                mem_write(4, 9);
                mem_write(8, 9);
                mem_write(12, 1);
                foreach (shadow_heads[i])
                begin
                    shadow_heads[i] = 0;
                end
                if (grow_shadow_heap(sfha_pkg::CHUNK_BYTES / 4) == 0)
                begin
                    r.st = sfha_pkg::ST_NOMEM;
                end
            end
            sfha_pkg::OP_ALLOC:
            begin
                if (req == 0)
                begin
                    r.st = sfha_pkg::ST_ZERO;
                end
                else if (shadow_break == 0)
                begin
                    r.st = sfha_pkg::ST_NOMEM;
                end
                else
                begin
                    asize = (req <= 8) ? 32'd16 : 32'd8 * ((32'(req) + 32'd15) / 32'd8);
                    bp = search_lists(asize);
                    if (bp == 0)
                    begin
                        ext = (asize > sfha_pkg::CHUNK_BYTES) ? asize
                            : 32'(sfha_pkg::CHUNK_BYTES);
                        bp = grow_shadow_heap(ext / 32'd4);
                    end
                    if (bp == 0)
                    begin
                        r.st = sfha_pkg::ST_NOMEM;
                    end
                    else
                    begin
                        place_block(bp, asize);
                        r.ad = bp[15:0];
                    end
                end
            end
            sfha_pkg::OP_FREE:
            begin
                if (shadow_break != 0 && addr[2:0] == 3'd0 && addr >= 16
                    && 32'(addr) < shadow_break)
                begin
                    hdr = mem_read(32'(addr) - 32'd4);
                    size = hdr & sfha_pkg::SIZE_MASK;
                    if (hdr[0] && size >= 16 && size <= shadow_break - 32'(addr))
                    begin
                        mem_write(32'(addr) - 32'd4, size);
                        mem_write(32'(addr) + size - 32'd8, size);
                        bp = coalesce(32'(addr));
                    end
                end
            end
            default:
            begin
            end
        endcase
        return r;
    endfunction

    // Predict one item, keep the bookkeeping of live blocks current and
    // queue the item for the driver.
    function automatic void queue_op(logic [1:0] op, logic [15:0] req, logic [15:0] addr);
        heap_op_t item;
        item.op = op;
        item.req = req;
        item.addr = addr;
        item.reply = heap_step(op, req, addr);
        if (op == sfha_pkg::OP_INIT)
        begin
            live_blocks.delete();
            released_blocks.delete();
        end
        if (op == sfha_pkg::OP_ALLOC && item.reply.st == sfha_pkg::ST_OK)
        begin
            live_blocks.push_back(item.reply.ad);
        end
        pending_ops.push_back(item);
    endfunction

    function automatic void release_live(int idx);
        bit [15:0] a;
        a = live_blocks[idx];
        live_blocks.delete(idx);
        released_blocks.push_back(a);
        queue_op(sfha_pkg::OP_FREE, 16'($urandom), a);
    endfunction

    // A free that the block rejects before it reads any header: misaligned,
    // too low, at or past the heap break, or sent before init.
    function automatic logic [15:0] rejected_address();
        logic [15:0] a;
        for (int k = 0; k < 16; k++)
        begin
            a = 16'($urandom);
            if (a[2:0] != 3'd0 || a < 16 || 32'(a) >= shadow_break || shadow_break == 0)
            begin
                return a;
            end
        end
        return {a[15:3], 3'd5};
    endfunction

    // A repeated free is safe to issue only while the old header still
    // reads as free, so the block drops it without changing the heap.
    function automatic void repeat_release();
        bit [15:0] a;
        a = released_blocks[$urandom_range(0, released_blocks.size() - 1)];
        if (32'(a) < shadow_break && mem_read(32'(a) - 32'd4) & 32'd1)
        begin
            queue_op(sfha_pkg::OP_FREE, 16'($urandom), rejected_address());
        end
        else
        begin
            queue_op(sfha_pkg::OP_FREE, 16'($urandom), a);
        end
    endfunction

    function automatic logic [15:0] random_request();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70)
        begin
            return 16'($urandom_range(1, 256));
        end
        else if (r < 90)
        begin
            return 16'($urandom_range(257, 4096));
        end
        else if (r < 97)
        begin
            return 16'($urandom_range(4097, 20000));
        end
        return 16'($urandom);
    endfunction

    // ------------------------------------------------------------------
    // Stimulus: a directed opening followed by a random stream.
    // ------------------------------------------------------------------
    initial
    begin
        int r;
        rst_n = 1'b0;
        error_count = 0;
        shadow_break = 0;

        // Directed part. Requests before init must fail and frees before
        // init must be ignored.
        queue_op(sfha_pkg::OP_ALLOC, 16'd24, 16'hFFFF);
        queue_op(sfha_pkg::OP_FREE, 16'hFFFF, 16'd16);
        queue_op(OP_NOP, 16'hFFFF, 16'hFFFF);
        queue_op(sfha_pkg::OP_INIT, 16'hFFFF, 16'hFFFF);
        // Zero size is ignored; 1 and 8 bytes round to the 16-byte minimum,
        // 9 bytes to 24.
        queue_op(sfha_pkg::OP_ALLOC, 16'd0, 16'h0);
        queue_op(sfha_pkg::OP_ALLOC, 16'd1, 16'h0);
        queue_op(sfha_pkg::OP_ALLOC, 16'd8, 16'h0);
        queue_op(sfha_pkg::OP_ALLOC, 16'd9, 16'h0);
        queue_op(sfha_pkg::OP_ALLOC, 16'd40, 16'h0);
        // More than the chunk size forces a growth by the request itself,
        // and the largest request cannot fit at all.
        queue_op(sfha_pkg::OP_ALLOC, 16'd5000, 16'h0);
        queue_op(sfha_pkg::OP_ALLOC, 16'hFFFF, 16'h0);
        // Frees that must be dropped: misaligned, below the first payload,
        // past the break.
        queue_op(sfha_pkg::OP_FREE, 16'h0, 16'd20);
        queue_op(sfha_pkg::OP_FREE, 16'h0, 16'd8);
        queue_op(sfha_pkg::OP_FREE, 16'h0, 16'hFFF8);
        // Coalescing: two isolated frees, one with free blocks on both sides,
        // one with a free successor, then a repeated free.
        release_live(1);
        release_live(2);
        release_live(1);
        release_live(0);
        repeat_release();
        queue_op(sfha_pkg::OP_ALLOC, 16'd100, 16'h0);
        // Exhaust the heap with large requests until growth fails.
        for (int k = 0; k < 5; k++)
        begin
            queue_op(sfha_pkg::OP_ALLOC, 16'd14000, 16'h0);
        end
        queue_op(sfha_pkg::OP_INIT, 16'h0, 16'h0);

        // Random part: mostly well-formed allocate and free traffic with
        // some junk frees, repeated frees, no-ops and occasional re-init.
        for (int k = 0; k < RANDOM_ITEMS; k++)
        begin
            r = $urandom_range(0, 99);
            if (live_blocks.size() > 60 && r >= 50)
            begin
                r = 30;
            end
            if (r < 1)
            begin
                queue_op(sfha_pkg::OP_INIT, 16'($urandom), 16'($urandom));
            end
            else if (r < 4)
            begin
                queue_op(OP_NOP, 16'($urandom), 16'($urandom));
            end
            else if (r < 8)
            begin
                queue_op(sfha_pkg::OP_FREE, 16'($urandom), rejected_address());
            end
            else if (r < 11 && released_blocks.size() > 0)
            begin
                repeat_release();
            end
            else if (r < 50 && live_blocks.size() > 0)
            begin
                release_live($urandom_range(0, live_blocks.size() - 1));
            end
            else
            begin
                queue_op(sfha_pkg::OP_ALLOC, random_request(), 16'($urandom));
            end
        end

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        // Wait until every item has gone in and every result has come back,
        // then give the block time to show any stray result.
        while (pending_ops.size() != 0 || in_valid || awaited_replies.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (200) @(posedge clk);
        if (error_count == 0 && awaited_replies.size() == 0)
        begin
            $display("PASS segregated_fit_heap_allocator");
        end
        else
        begin
            $display("FAIL segregated_fit_heap_allocator");
        end
        $finish;
    end

    // ------------------------------------------------------------------
    // Driver. Before presenting each item it waits a drawn number of
    // cycles; every fourth stretch of 150 items runs with no gaps at all.
    // The expected result is queued at the edge where the item is taken.
    // ------------------------------------------------------------------
    heap_op_t drive_item;
    int       gap_left;
    int       items_sent;

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid      <= 1'b0;
            opcode        <= OP_NOP;
            request_size  <= '0;
            block_address <= '0;
            gap_left = 0;
            items_sent = 0;
        end
        else
        begin
            if (in_valid && !in_stall)
            begin
                awaited_replies.push_back(drive_item.reply);
                items_sent++;
            end
            if (!in_valid || !in_stall)
            begin
                if (gap_left > 0)
                begin
                    gap_left--;
                    in_valid <= 1'b0;
                end
                else if (pending_ops.size() > 0)
                begin
                    drive_item = pending_ops.pop_front();
                    opcode        <= drive_item.op;
                    request_size  <= drive_item.req;
                    block_address <= drive_item.addr;
                    in_valid      <= 1'b1;
                    gap_left = ((items_sent / 150) % 4 == 3) ? 0 : $urandom_range(0, 7);
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Monitor. Each result is checked against the oldest expectation. The
    // receiver stalls a drawn number of cycles after each result, with
    // calm stretches. A separate process holds the receiver off once for
    // a long stretch so that the output register fills and the block
    // stalls its input.
    // ------------------------------------------------------------------
    reply_t want;
    int     stall_left;
    int     results_seen;
    logic   draw_stall;
    logic   hold_stall;
    int     hold_cycles;

    assign out_stall = draw_stall || hold_stall;

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_stall <= 1'b0;
            hold_cycles = 0;
        end
        else
        begin
            hold_cycles++;
            hold_stall <= (hold_cycles >= HOLD_START)
                       && (hold_cycles < HOLD_START + HOLD_CYCLES);
        end
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            draw_stall <= 1'b0;
            stall_left = 0;
            results_seen = 0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (awaited_replies.size() == 0)
                begin
                    $error("result with no item outstanding: status %0d, address %0d",
                           status, address);
                    error_count++;
                end
                else
                begin
                    want = awaited_replies.pop_front();
                    if (status !== want.st)
                    begin
                        $error("status mismatch: expected %0d, got %0d", want.st, status);
                        error_count++;
                    end
                    if (address !== want.ad)
                    begin
                        $error("address mismatch: expected %0d, got %0d", want.ad, address);
                        error_count++;
                    end
                end
                results_seen++;
                stall_left = ((results_seen / 150) % 4 == 1) ? 0 : $urandom_range(0, 7);
            end
            else if (stall_left > 0)
            begin
                stall_left--;
            end
            draw_stall <= (stall_left > 0);
        end
    end

    // Watchdog: any item moving on either side restarts the count.
    int idle_cycles;

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idle_cycles = 0;
        end
        else
        begin
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
            begin
                idle_cycles = 0;
            end
            else
            begin
                idle_cycles++;
            end
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("FAIL segregated_fit_heap_allocator");
                $finish;
            end
        end
    end

endmodule

### segregated_fit_heap_allocator.f
sv/sfha_pkg.sv
sv/sfha_heap_ram.sv
sv/segregated_fit_heap_allocator.sv
test/tb_segregated_fit_heap_allocator.sv
